/* rtl/core/diff_drive_waypoint_steer_unit_assert.svh */
// Assertion macros for the waypoint steering unit checkers.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DIFF_DRIVE_WAYPOINT_STEER_UNIT_ASSERT_SVH
`define DIFF_DRIVE_WAYPOINT_STEER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DDWS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddws assertion failed");

// Next-cycle implication, disabled during reset.
`define DDWS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddws assertion failed");

`endif

/* rtl/core/ddws_pkg.sv */
// Shared constants, types and functions of the waypoint steering unit.
// No dependencies; the top level and ddws_cordic refer to it by scoped names.
package ddws_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W = 5;

    localparam int D_W = 17;
    localparam int X_W = 36;
    localparam int Z_W = 20;
    localparam int ANG_W = Z_W - 3;
    localparam int ERR_W = ANG_W + 1;
    localparam int MB_W = 17;
    localparam int P_W = X_W + MB_W;
    localparam int DIST_W = 18;
    localparam int C_W = 22;

    localparam logic signed [Z_W-1:0] PI_Q16 = Z_W'(205887);
    localparam logic [15:0] CORDIC_GAIN_Q16 = 16'd39797;

    localparam logic [14:0] RST_POS_DZ = 15'd128;
    localparam logic [14:0] RST_ROT_ENTER = 15'd1638;
    localparam logic [14:0] RST_ROT_HOLD = 15'd205;
    localparam logic [15:0] RST_POS_GAIN = 16'd2458;
    localparam logic [15:0] RST_ROT_GAIN = 16'd6144;
    localparam logic [2:0] RST_WHEELS = 3'd2;

    localparam logic [2:0] WHEELS_TWO = 3'd2;
    localparam logic [2:0] WHEELS_FOUR = 3'd4;

    typedef enum logic [2:0] {
        CFG_POS_DZ = 3'd0,
        CFG_ROT_ENTER = 3'd1,
        CFG_ROT_HOLD = 3'd2,
        CFG_POS_GAIN = 3'd3,
        CFG_ROT_GAIN = 3'd4,
        CFG_WHEELS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic done;
        logic signed [X_W-1:0] mag_raw;
        logic signed [Z_W-1:0] angle;
    } cordic_res_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0: r = Z_W'(51472);
            5'd1: r = Z_W'(30386);
            5'd2: r = Z_W'(16055);
            5'd3: r = Z_W'(8150);
            5'd4: r = Z_W'(4091);
            5'd5: r = Z_W'(2047);
            5'd6: r = Z_W'(1024);
            5'd7: r = Z_W'(512);
            5'd8: r = Z_W'(256);
            5'd9: r = Z_W'(128);
            5'd10: r = Z_W'(64);
            5'd11: r = Z_W'(32);
            5'd12: r = Z_W'(16);
            5'd13: r = Z_W'(8);
            5'd14: r = Z_W'(4);
            5'd15: r = Z_W'(2);
            5'd16: r = Z_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [C_W:0] v);
        logic signed [15:0] r;
        if (v > (C_W+1)'(32767))
        begin
            r = 16'sh7FFF;
        end
        else if (v < -(C_W+1)'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/ddws_if.sv */
// Handshake channel interfaces of the waypoint steering unit: pose input and speed command output.
// Depends on nothing; the payload widths follow the block's field definitions.
interface ddws_pose_if;
    logic valid;
    logic ready;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;

    modport source (output valid, pose_x, pose_y, pose_heading, target_x, target_y,
                    input ready);
    modport sink (input valid, pose_x, pose_y, pose_heading, target_x, target_y,
                  output ready);
endinterface

interface ddws_cmd_if;
    logic valid;
    logic ready;
    logic signed [15:0] speed_slot0;
    logic signed [15:0] speed_slot1;
    logic signed [15:0] speed_slot2;
    logic signed [15:0] speed_slot3;
    logic [2:0] slot_count;
    logic waypoint_reached;
    logic [15:0] request_index;
    logic turning;

    modport source (output valid, speed_slot0, speed_slot1, speed_slot2, speed_slot3,
                    slot_count, waypoint_reached, request_index, turning,
                    input ready);
    modport sink (input valid, speed_slot0, speed_slot1, speed_slot2, speed_slot3,
                  slot_count, waypoint_reached, request_index, turning,
                  output ready);
endinterface

/* rtl/core/diff_drive_waypoint_steer_unit.sv */
// Top level of the differential-drive waypoint steering unit.
// Depends on ddws_pkg, the channel interfaces in ddws_if.sv and ddws_cordic.

// Each accepted pose transaction yields one speed command transaction, which is
// registered after the vectoring, decide, scale and finish states, once the output
// register is free. The input is ready again as soon as the command is registered,
// so no new pose transaction is taken before the last one is through. The pace is
// set by the iterative CORDIC, which resolves one step per cycle, and by a
// single shared multiplier used in turn for magnitude scaling and for the
// speed gain. A finished command waits in the output register while the
// next pose transaction is taken; configuration writes must be made only
// while the unit is idle.
module diff_drive_waypoint_steer_unit
(
    input  logic clk,
    input  logic rst_n,
    ddws_pose_if.sink pose,
    ddws_cmd_if.source cmd,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VECTOR,
        S_DECIDE,
        S_SCALE,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [14:0] pos_dz_reg;
    logic [14:0] rot_enter_reg;
    logic [14:0] rot_hold_reg;
    logic [15:0] pos_gain_reg;
    logic [15:0] rot_gain_reg;
    logic [2:0] wheels_reg;

    logic rotating_reg;
    logic [15:0] counter_reg;

    logic signed [15:0] heading_reg;
    logic signed [ddws_pkg::ANG_W-1:0] ang_reg;
    logic signed [ddws_pkg::P_W-1:0] prod_reg;
    logic signed [ddws_pkg::ERR_W-1:0] err_reg;
    logic [ddws_pkg::DIST_W-1:0] dist_reg;
    logic turn_reg;
    logic reached_reg;
    logic [15:0] req_reg;

    logic out_valid_reg;
    logic signed [15:0] slot0_reg;
    logic signed [15:0] slot1_reg;
    logic signed [15:0] slot2_reg;
    logic signed [15:0] slot3_reg;
    logic [2:0] count_reg;
    logic out_reached_reg;
    logic [15:0] out_req_reg;
    logic out_turn_reg;

    logic in_accept;
    logic signed [15:0] tgt_x;
    logic signed [15:0] tgt_y;
    logic signed [ddws_pkg::D_W-1:0] dx;
    logic signed [ddws_pkg::D_W-1:0] dy;
    ddws_pkg::cordic_res_t cres;

    logic signed [ddws_pkg::X_W-1:0] mul_a;
    logic signed [ddws_pkg::MB_W-1:0] mul_b;
    logic signed [ddws_pkg::P_W-1:0] mul_p;

    logic signed [ddws_pkg::Z_W:0] ang_sum;
    logic signed [ddws_pkg::P_W-1:0] dist_sum;
    logic [ddws_pkg::DIST_W-1:0] dist_val;
    logic signed [ddws_pkg::ERR_W-1:0] err_val;
    logic [ddws_pkg::ERR_W-1:0] aerr;
    logic [14:0] thr;
    logic turn_next;
    logic reached_next;

    logic signed [ddws_pkg::P_W-1:0] round_sum;
    logic signed [ddws_pkg::P_W-1:0] round_sh;
    logic signed [ddws_pkg::C_W-1:0] c_val;
    logic signed [ddws_pkg::C_W:0] vr_wide;
    logic signed [ddws_pkg::C_W:0] vl_wide;
    logic signed [15:0] vr;
    logic signed [15:0] vl;
    logic out_free;

    assign in_accept = pose.valid && pose.ready;
    assign pose.ready = (state_reg == S_IDLE);

    // The origin is the target while the waypoint counter is zero.
    assign tgt_x = (counter_reg != '0) ? pose.target_x : '0;
    assign tgt_y = (counter_reg != '0) ? pose.target_y : '0;
    assign dx = ddws_pkg::D_W'(tgt_x) - ddws_pkg::D_W'(pose.pose_x);
    assign dy = ddws_pkg::D_W'(tgt_y) - ddws_pkg::D_W'(pose.pose_y);

    ddws_cordic u_cordic
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(in_accept),
        .dx(dx),
        .dy(dy),
        .res(cres)
    );

    // The shared multiplier scales the CORDIC magnitude first and the speed gain later.
    always_comb
    begin
        if (state_reg == S_VECTOR)
        begin
            mul_a = cres.mag_raw;
            mul_b = {1'b0, ddws_pkg::CORDIC_GAIN_Q16};
        end
        else if (turn_reg)
        begin
            mul_a = ddws_pkg::X_W'(err_reg);
            mul_b = {1'b0, rot_gain_reg};
        end
        else
        begin
            mul_a = ddws_pkg::X_W'({1'b0, dist_reg});
            mul_b = {1'b0, pos_gain_reg};
        end
        mul_p = ddws_pkg::P_W'(mul_a) * ddws_pkg::P_W'(mul_b);
    end

    assign ang_sum = ddws_pkg::Z_W'(cres.angle) + (ddws_pkg::Z_W+1)'(8);

    always_comb
    begin
        dist_sum = prod_reg + ddws_pkg::P_W'(64'sd2147483648);
        dist_val = dist_sum[32 +: ddws_pkg::DIST_W];
        err_val = ddws_pkg::ERR_W'(ang_reg) - ddws_pkg::ERR_W'(heading_reg);
        aerr = err_val[ddws_pkg::ERR_W-1] ? ddws_pkg::ERR_W'(-err_val) : err_val;
        thr = rotating_reg ? rot_hold_reg : rot_enter_reg;
        // An error inside the hold band counts as zero and never turns.
        turn_next = (aerr > ddws_pkg::ERR_W'(rot_hold_reg)) && (aerr > ddws_pkg::ERR_W'(thr));
        reached_next = !turn_next && (dist_val <= ddws_pkg::DIST_W'(pos_dz_reg));
    end

    always_comb
    begin
        if (turn_reg)
        begin
            round_sum = prod_reg + ddws_pkg::P_W'(32768);
            round_sh = round_sum >>> 16;
        end
        else
        begin
            round_sum = prod_reg + ddws_pkg::P_W'(2048);
            round_sh = round_sum >>> 12;
        end
        c_val = round_sh[ddws_pkg::C_W-1:0];
        vl_wide = (ddws_pkg::C_W+1)'(c_val);
        vr_wide = turn_reg ? -vl_wide : vl_wide;
        vr = ddws_pkg::sat16(vr_wide);
        vl = ddws_pkg::sat16(vl_wide);
    end

    assign out_free = !out_valid_reg || cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_dz_reg <= ddws_pkg::RST_POS_DZ;
            rot_enter_reg <= ddws_pkg::RST_ROT_ENTER;
            rot_hold_reg <= ddws_pkg::RST_ROT_HOLD;
            pos_gain_reg <= ddws_pkg::RST_POS_GAIN;
            rot_gain_reg <= ddws_pkg::RST_ROT_GAIN;
            wheels_reg <= ddws_pkg::RST_WHEELS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddws_pkg::CFG_POS_DZ: pos_dz_reg <= cfg_wdata[14:0];
                ddws_pkg::CFG_ROT_ENTER: rot_enter_reg <= cfg_wdata[14:0];
                ddws_pkg::CFG_ROT_HOLD: rot_hold_reg <= cfg_wdata[14:0];
                ddws_pkg::CFG_POS_GAIN: pos_gain_reg <= cfg_wdata;
                ddws_pkg::CFG_ROT_GAIN: rot_gain_reg <= cfg_wdata;
                ddws_pkg::CFG_WHEELS: wheels_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rotating_reg <= 1'b0;
            counter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && cmd.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        heading_reg <= pose.pose_heading;
                        state_reg <= S_VECTOR;
                    end
                end
                S_VECTOR:
                begin
                    if (cres.done)
                    begin
                        prod_reg <= mul_p;
                        ang_reg <= ang_sum[ddws_pkg::Z_W:4];
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    err_reg <= err_val;
                    turn_reg <= turn_next;
                    reached_reg <= reached_next;
                    rotating_reg <= turn_next;
                    dist_reg <= reached_next ? '0 : dist_val;
                    req_reg <= reached_next ? counter_reg : '0;
                    if (reached_next)
                    begin
                        counter_reg <= counter_reg + 1'b1;
                    end
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    prod_reg <= mul_p;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reached_reg <= reached_reg;
                        out_req_reg <= req_reg;
                        out_turn_reg <= turn_reg;
                        if (wheels_reg == ddws_pkg::WHEELS_TWO)
                        begin
                            slot0_reg <= vr;
                            slot1_reg <= vl;
                            slot2_reg <= '0;
                            slot3_reg <= '0;
                            count_reg <= ddws_pkg::WHEELS_TWO;
                        end
                        else if (wheels_reg == ddws_pkg::WHEELS_FOUR)
                        begin
                            slot0_reg <= vl;
                            slot1_reg <= vr;
                            slot2_reg <= vl;
                            slot3_reg <= vr;
                            count_reg <= ddws_pkg::WHEELS_FOUR;
                        end
                        else
                        begin
                            slot0_reg <= '0;
                            slot1_reg <= '0;
                            slot2_reg <= '0;
                            slot3_reg <= '0;
                            count_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.valid = out_valid_reg;
    assign cmd.speed_slot0 = slot0_reg;
    assign cmd.speed_slot1 = slot1_reg;
    assign cmd.speed_slot2 = slot2_reg;
    assign cmd.speed_slot3 = slot3_reg;
    assign cmd.slot_count = count_reg;
    assign cmd.waypoint_reached = out_reached_reg;
    assign cmd.request_index = out_req_reg;
    assign cmd.turning = out_turn_reg;

endmodule

/* rtl/core/ddws_cordic.sv */
// Iterative vectoring CORDIC that yields bearing and unscaled magnitude of (dx, dy).
// Depends on ddws_pkg for widths, the step count and the arctangent table.
module ddws_cordic
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [ddws_pkg::D_W-1:0] dx,
    input  logic signed [ddws_pkg::D_W-1:0] dy,
    output ddws_pkg::cordic_res_t res
);

    logic signed [ddws_pkg::X_W-1:0] x_reg;
    logic signed [ddws_pkg::X_W-1:0] y_reg;
    logic signed [ddws_pkg::Z_W-1:0] z_reg;
    logic [ddws_pkg::STEP_W-1:0] step_reg;
    logic busy_reg;
    logic done_reg;
    logic zero_reg;

    logic signed [ddws_pkg::X_W-17:0] dx_ext;
    logic signed [ddws_pkg::X_W-17:0] dy_ext;
    logic signed [ddws_pkg::X_W-17:0] x_init;
    logic signed [ddws_pkg::X_W-17:0] y_init;
    logic signed [ddws_pkg::Z_W-1:0] z_init;
    logic signed [ddws_pkg::X_W-1:0] x_sh;
    logic signed [ddws_pkg::X_W-1:0] y_sh;
    logic signed [ddws_pkg::Z_W-1:0] atan_val;

    // Vectors in the left half plane are rotated by pi before iterating.
    always_comb
    begin
        dx_ext = (ddws_pkg::X_W-16)'(dx);
        dy_ext = (ddws_pkg::X_W-16)'(dy);
        if (dx[ddws_pkg::D_W-1])
        begin
            x_init = -dx_ext;
            y_init = -dy_ext;
            z_init = dy[ddws_pkg::D_W-1] ? -ddws_pkg::PI_Q16 : ddws_pkg::PI_Q16;
        end
        else
        begin
            x_init = dx_ext;
            y_init = dy_ext;
            z_init = '0;
        end
    end

    assign x_sh = x_reg >>> step_reg;
    assign y_sh = y_reg >>> step_reg;
    assign atan_val = ddws_pkg::atan_q16(ddws_pkg::ATAN_IDX_W'(step_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                zero_reg <= (dx == '0) && (dy == '0);
            end
            else if (busy_reg)
            begin
                if (step_reg == ddws_pkg::STEP_W'(ddws_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= {x_init, 16'b0};
            y_reg <= {y_init, 16'b0};
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            if (!y_reg[ddws_pkg::X_W-1])
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val;
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val;
            end
        end
    end

    assign res.done = done_reg;
    assign res.mag_raw = zero_reg ? '0 : x_reg;
    assign res.angle = zero_reg ? '0 : z_reg;

endmodule

/* rtl/core/ddws_checker.sv */
// Port-level checker for the waypoint steering unit and the bind that attaches it.
// Depends on the assertion macros in diff_drive_waypoint_steer_unit_assert.svh.
`include "diff_drive_waypoint_steer_unit_assert.svh"

module ddws_checker
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic signed [15:0] speed_slot2,
    input logic signed [15:0] speed_slot3,
    input logic [2:0] slot_count,
    input logic waypoint_reached,
    input logic [15:0] request_index,
    input logic turning
);

    `DDWS_ASSERT_NXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid)
    `DDWS_ASSERT_IMP(a_slot_count, cmd_valid, slot_count == 3'd0 || slot_count == 3'd2 || slot_count == 3'd4)
    `DDWS_ASSERT_IMP(a_turn_not_reached, cmd_valid && turning, !waypoint_reached)
    `DDWS_ASSERT_IMP(a_upper_slots, cmd_valid && slot_count != 3'd4, speed_slot2 == '0 && speed_slot3 == '0)
    `DDWS_ASSERT_IMP(a_req_idle, cmd_valid && !waypoint_reached, request_index == '0)

endmodule

bind diff_drive_waypoint_steer_unit ddws_checker u_ddws_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(cmd.valid),
    .cmd_ready(cmd.ready),
    .speed_slot2(cmd.speed_slot2),
    .speed_slot3(cmd.speed_slot3),
    .slot_count(cmd.slot_count),
    .waypoint_reached(cmd.waypoint_reached),
    .request_index(cmd.request_index),
    .turning(cmd.turning)
);
